FILE: src/dq_pkg.sv
`timescale 1ns / 1ps
// Package for the double-ended queue core: operation codes, status codes,
// controller states and the result record. It depends on nothing else.
package dq_pkg;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_QUERY      = 3'd4;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         occupancy;
    logic               is_empty;
  } result_t;

endpackage

FILE: src/dq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the double-ended queue core.
// They depend on dq_pkg for the status code type.
interface dq_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface dq_out_if;
  logic               valid;
  logic               ready;
  dq_pkg::status_e    status;
  logic signed [31:0] popped_value;
  logic signed [31:0] front_value;
  logic signed [31:0] back_value;
  logic [4:0]         occupancy;
  logic               is_empty;

  modport source (output valid, output status, output popped_value, output front_value,
                  output back_value, output occupancy, output is_empty, input ready);
  modport sink (input valid, input status, input popped_value, input front_value,
                input back_value, input occupancy, input is_empty, output ready);
endinterface

FILE: src/double_ended_queue_core.sv
`timescale 1ns / 1ps
// A push, a query, a failed operation, or a pop that leaves at most one value has
// its result registered at acceptance; any other pop first passes through ST_READ,
// where the registered read port of the ring memory delivers the new end value.
// One transaction per cycle is taken while the skid register is empty and not in ST_READ.
// Reset clears the indices, the count and the handshake state; the memory is not cleared.
// Depends on dq_pkg and the interfaces in dq_if.sv.
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == AW'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
    logic [AW-1:0] r;
    if (i == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = i - 1'b1;
    end
    return r;
  endfunction

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  state_e             state_q, state_d;
  logic [AW-1:0]      front_q, front_d;
  logic [AW-1:0]      back_q, back_d;
  logic [CW-1:0]      count_q, count_d;
  logic signed [31:0] fcache_q, fcache_d;
  logic signed [31:0] bcache_q, bcache_d;
  logic signed [31:0] pop_val_q, pop_val_d;
  logic               pop_front_q, pop_front_d;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [AW-1:0]      raddr;
  logic               res_valid;
  status_e            res_status;
  logic signed [31:0] res_popped;
  result_t            res;

  logic               out_valid_q, skid_valid_q;
  result_t            out_q, skid_q;
  logic               in_acc, out_take;
  logic               is_push, is_pop, is_full, is_none;

  assign in_i.ready = (state_q == ST_IDLE) && !skid_valid_q;
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_take   = out_valid_q && out_o.ready;

  assign is_push = (in_i.kind == KIND_PUSH_FRONT) || (in_i.kind == KIND_PUSH_BACK);
  assign is_pop  = (in_i.kind == KIND_POP_FRONT) || (in_i.kind == KIND_POP_BACK);
  assign is_full = (count_q == CW'(DEPTH));
  assign is_none = (count_q == '0);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    back_d      = back_q;
    count_d     = count_q;
    fcache_d    = fcache_q;
    bcache_d    = bcache_q;
    pop_val_d   = pop_val_q;
    pop_front_d = pop_front_q;
    we          = 1'b0;
    waddr       = back_q;
    raddr       = idx_inc(front_q);
    res_valid   = 1'b0;
    res_status  = STATUS_OK;
    res_popped  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          res_valid = 1'b1;
          priority if (is_push && is_full) begin
            res_status = STATUS_FULL;
          end else if (is_pop && is_none) begin
            res_status = STATUS_EMPTY;
          end else if (in_i.kind == KIND_PUSH_FRONT) begin
            we       = 1'b1;
            front_d  = idx_dec(front_q);
            waddr    = front_d;
            count_d  = count_q + 1'b1;
            fcache_d = in_i.value;
            if (is_none) begin
              bcache_d = in_i.value;
            end
          end else if (in_i.kind == KIND_PUSH_BACK) begin
            we       = 1'b1;
            waddr    = back_q;
            back_d   = idx_inc(back_q);
            count_d  = count_q + 1'b1;
            bcache_d = in_i.value;
            if (is_none) begin
              fcache_d = in_i.value;
            end
          end else if (in_i.kind == KIND_POP_FRONT) begin
            res_popped  = fcache_q;
            pop_val_d   = fcache_q;
            pop_front_d = 1'b1;
            front_d     = idx_inc(front_q);
            count_d     = count_q - 1'b1;
            raddr       = front_d;
            if (count_q == CW'(2)) begin
              fcache_d = bcache_q;
            end else if (count_q != CW'(1)) begin
              res_valid = 1'b0;
              state_d   = ST_READ;
            end
          end else if (in_i.kind == KIND_POP_BACK) begin
            res_popped  = bcache_q;
            pop_val_d   = bcache_q;
            pop_front_d = 1'b0;
            back_d      = idx_dec(back_q);
            count_d     = count_q - 1'b1;
            raddr       = idx_dec(back_d);
            if (count_q == CW'(2)) begin
              bcache_d = fcache_q;
            end else if (count_q != CW'(1)) begin
              res_valid = 1'b0;
              state_d   = ST_READ;
            end
          end else begin
            res_status = STATUS_OK;
          end
        end
      end
      ST_READ: begin
        res_valid  = 1'b1;
        res_popped = pop_val_q;
        state_d    = ST_IDLE;
        if (pop_front_q) begin
          fcache_d = rdata_q;
        end else begin
          bcache_d = rdata_q;
        end
      end
    endcase
  end

  always_comb begin
    res.status       = res_status;
    res.popped_value = res_popped;
    res.front_value  = (count_d == '0) ? '0 : fcache_d;
    res.back_value   = (count_d == '0) ? '0 : bcache_d;
    res.occupancy    = 5'(count_d);
    res.is_empty     = (count_d == '0);
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_i.value;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      front_q      <= '0;
      back_q       <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      if (res_valid) begin
        if (!out_valid_q || out_take) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q  <= skid_valid_q;
        skid_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fcache_q    <= fcache_d;
    bcache_q    <= bcache_d;
    pop_val_q   <= pop_val_d;
    pop_front_q <= pop_front_d;
    if (res_valid) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end else if (out_take && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.popped_value = out_q.popped_value;
  assign out_o.front_value  = out_q.front_value;
  assign out_o.back_value   = out_q.back_value;
  assign out_o.occupancy    = out_q.occupancy;
  assign out_o.is_empty     = out_q.is_empty;

endmodule
